[hw/rtl/bsws_pkg.sv]
// Shared types and constants for the bounded stack with search.
// No dependencies; used by bsws_ctrl, bsws_dp and the top level.
package bsws_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 6;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 6'd32;
  localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_POP_FIN,
    ST_SRCH,
    ST_SRCH_FIN,
    ST_DUMP,
    ST_DUMP_FIN
  } state_e;

  // What goes into the result register this cycle
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_EMPTY,
    EMIT_RD,
    EMIT_FOUND
  } emit_e;

  typedef struct packed {
    logic  wr_en;
    logic  fill_dec;
    logic  rd_en;
    logic  rd_top;
    logic  rd_last;
    logic  idx_clr;
    logic  idx_load_top;
    logic  idx_inc;
    logic  idx_dec;
    logic  hit_clr;
    logic  latch_val;
    emit_e emit;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic push_ok;
    logic idx_zero;
    logic idx_top;
    logic rd_vld;
  } sts_t;

endpackage

[hw/rtl/bsws_ctrl.sv]
// Controller state machine for the bounded stack with search.
// Depends on bsws_pkg; drives bsws_dp through cmd_t and reads sts_t.
module bsws_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic [1:0]      op_i,
  input  bsws_pkg::sts_t  sts_i,
  output bsws_pkg::cmd_t  cmd_o,
  output logic            busy
);

  bsws_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsws_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit = bsws_pkg::EMIT_NONE;
    unique case (state_q)
      bsws_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.latch_val = 1'b1;
          unique case (bsws_pkg::op_e'(op_i))
            bsws_pkg::OP_PUSH: begin
              // full or over capacity: drop the word
              cmd_o.wr_en = sts_i.push_ok;
            end
            bsws_pkg::OP_POP: begin
              state_d = bsws_pkg::ST_POP;
            end
            bsws_pkg::OP_SEARCH: begin
              cmd_o.idx_clr = 1'b1;
              cmd_o.hit_clr = 1'b1;
              state_d       = bsws_pkg::ST_SRCH;
            end
            bsws_pkg::OP_DUMP: begin
              cmd_o.idx_load_top = 1'b1;
              state_d            = bsws_pkg::ST_DUMP;
            end
            default: state_d = bsws_pkg::ST_IDLE;
          endcase
        end
      end
      bsws_pkg::ST_POP: begin
        if (sts_i.fill_zero) begin
          cmd_o.emit = bsws_pkg::EMIT_EMPTY;
          state_d    = bsws_pkg::ST_IDLE;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_top   = 1'b1;
          cmd_o.rd_last  = 1'b1;
          cmd_o.fill_dec = 1'b1;
          state_d        = bsws_pkg::ST_POP_FIN;
        end
      end
      bsws_pkg::ST_POP_FIN: begin
        cmd_o.emit = bsws_pkg::EMIT_RD;
        state_d    = bsws_pkg::ST_IDLE;
      end
      bsws_pkg::ST_SRCH: begin
        if (sts_i.fill_zero) begin
          cmd_o.emit = bsws_pkg::EMIT_FOUND;
          state_d    = bsws_pkg::ST_IDLE;
        end else begin
          // read one entry a cycle, compare it the cycle after
          cmd_o.rd_en   = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (sts_i.idx_top) begin
            state_d = bsws_pkg::ST_SRCH_FIN;
          end
        end
      end
      bsws_pkg::ST_SRCH_FIN: begin
        cmd_o.emit = bsws_pkg::EMIT_FOUND;
        state_d    = bsws_pkg::ST_IDLE;
      end
      bsws_pkg::ST_DUMP: begin
        if (sts_i.fill_zero) begin
          cmd_o.emit = bsws_pkg::EMIT_EMPTY;
          state_d    = bsws_pkg::ST_IDLE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_last = sts_i.idx_zero;
          cmd_o.idx_dec = 1'b1;
          if (sts_i.rd_vld) begin
            cmd_o.emit = bsws_pkg::EMIT_RD;
          end
          if (sts_i.idx_zero) begin
            state_d = bsws_pkg::ST_DUMP_FIN;
          end
        end
      end
      bsws_pkg::ST_DUMP_FIN: begin
        cmd_o.emit = bsws_pkg::EMIT_RD;
        state_d    = bsws_pkg::ST_IDLE;
      end
      default: state_d = bsws_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_q != bsws_pkg::ST_IDLE);

  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> (state_q == bsws_pkg::ST_IDLE) && start)
    else $error("stack write outside an accepted push");

  a_srch_fin_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsws_pkg::ST_SRCH_FIN) |=> (state_q == bsws_pkg::ST_IDLE))
    else $error("search did not end after its final compare");

  a_pop_fin_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsws_pkg::ST_POP_FIN) |-> sts_i.rd_vld)
    else $error("pop result without read data");

endmodule

[hw/rtl/bsws_dp.sv]
// Datapath for the bounded stack with search: stack memory, fill count,
// walk index, capacity register and result register. Depends on bsws_pkg.
module bsws_dp #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bsws_pkg::cmd_t                  cmd_i,
  output bsws_pkg::sts_t                  sts_o,
  input  logic signed [bsws_pkg::WORD_W-1:0] value_i,
  input  logic                            cfg_we_i,
  input  logic [bsws_pkg::CAP_W-1:0]      cfg_data_i,
  output logic                            res_valid_o,
  output logic signed [bsws_pkg::WORD_W-1:0] data_o,
  output logic                            found_o,
  output logic                            empty_res_o,
  output logic                            last_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (FW > bsws_pkg::CAP_W) ? FW : bsws_pkg::CAP_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

  logic [bsws_pkg::WORD_W-1:0] mem [DEPTH];

  logic [bsws_pkg::CAP_W-1:0]  cap_q;
  logic [FW-1:0]               fill_q, fill_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [FW-1:0]               top_w;
  logic [AW-1:0]               rd_addr;
  logic [bsws_pkg::WORD_W-1:0] rd_data_q;
  logic                        rd_vld_q;
  logic                        rd_last_q;
  logic [bsws_pkg::WORD_W-1:0] value_q;
  logic                        hit_q;
  logic                        match;
  logic [CMPW-1:0]             fill_x, cap_x;

  logic                        res_valid_q;
  logic [bsws_pkg::WORD_W-1:0] data_q;
  logic                        found_q, empty_q, last_q;

  assign top_w  = fill_q - FW'(1);
  assign fill_x = CMPW'(fill_q);
  assign cap_x  = CMPW'(cap_q);

  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.push_ok   = (fill_x < cap_x) && (fill_x < DEPTH_C);
  assign sts_o.idx_zero  = (idx_q == '0);
  assign sts_o.idx_top   = ((FW'(idx_q) + FW'(1)) == fill_q);
  assign sts_o.rd_vld    = rd_vld_q;

  assign rd_addr = cmd_i.rd_top ? top_w[AW-1:0] : idx_q;
  assign match   = (rd_data_q == value_q);

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.wr_en) begin
      fill_d = fill_q + FW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = top_w;
    end
  end

  always_comb begin
    priority if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_load_top) begin
      idx_d = top_w[AW-1:0];
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - AW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[fill_q[AW-1:0]] <= value_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= bsws_pkg::CAP_RESET;
      fill_q    <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.rd_en) begin
        rd_last_q <= cmd_i.rd_last;
      end
      if (cmd_i.hit_clr) begin
        hit_q <= 1'b0;
      end else if (rd_vld_q && match) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_val) begin
      value_q <= value_i;
    end
  end

  // Result register: each word shows for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.emit != bsws_pkg::EMIT_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.emit)
      bsws_pkg::EMIT_EMPTY: begin
        data_q  <= bsws_pkg::EMPTY_WORD;
        found_q <= 1'b0;
        empty_q <= 1'b1;
        last_q  <= 1'b1;
      end
      bsws_pkg::EMIT_RD: begin
        data_q  <= rd_data_q;
        found_q <= 1'b0;
        empty_q <= 1'b0;
        last_q  <= rd_last_q;
      end
      bsws_pkg::EMIT_FOUND: begin
        data_q  <= '0;
        found_q <= hit_q | (rd_vld_q & match);
        empty_q <= 1'b0;
        last_q  <= 1'b1;
      end
      default: begin
        data_q  <= data_q;
        found_q <= found_q;
        empty_q <= empty_q;
        last_q  <= last_q;
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign data_o      = data_q;
  assign found_o     = found_q;
  assign empty_res_o = empty_q;
  assign last_o      = last_q;

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(fill_q) <= DEPTH_C)
    else $error("fill count beyond depth");

  a_no_pop_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_dec |-> (fill_q != '0))
    else $error("pop from an empty stack");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |=> (fill_q == $past(fill_q) + FW'(1)))
    else $error("push did not advance the fill count");

endmodule

[hw/rtl/bounded_stack_with_search_top.sv]
// Top level of the bounded stack with search.
// Depends on bsws_pkg, bsws_ctrl and bsws_dp.
//
// Usage: drive op_i/value_i and raise start; the word is taken at a clock
// edge where start is high and busy is low. Push (op 0) finishes in the
// accept cycle, gives no result and busy stays low. Pop (op 1) reads the
// top entry in ST_POP and gives one result from ST_POP_FIN. Search (op 2)
// walks the stack from the bottom, one entry per cycle through the single
// memory read port, and reports found with last set after its final
// compare. Dump (op 3) streams every stored word top to bottom, one per
// cycle, with last on the bottom one; an empty pop, search or dump gives
// its one result without reading the memory, and an empty pop or dump
// gives data -1 with empty_res set.
// Each result shows on the result ports for exactly one cycle with
// res_valid_o high; the receiver cannot stall, so results are never held.
// A new command may be accepted in the cycle its predecessor's final result
// is shown. Capacity is written on the cfg channel (valid and ready high);
// ready is low while busy. Reset empties the stack and sets capacity to 32;
// capacity above DEPTH acts as DEPTH.
module bounded_stack_with_search_top #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         op_i,
  input  logic signed [bsws_pkg::WORD_W-1:0] value_i,
  output logic                               res_valid_o,
  output logic signed [bsws_pkg::WORD_W-1:0] data_o,
  output logic                               found_o,
  output logic                               empty_res_o,
  output logic                               last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bsws_pkg::CAP_W-1:0]         cfg_data_i
);

  bsws_pkg::cmd_t cmd;
  bsws_pkg::sts_t sts;
  logic           busy_w;

  bsws_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy_w)
  );

  bsws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     (value_i),
    .cfg_we_i    (cfg_valid_i & ~busy_w),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .data_o      (data_o),
    .found_o     (found_o),
    .empty_res_o (empty_res_o),
    .last_o      (last_o)
  );

  assign busy        = busy_w;
  assign cfg_ready_o = ~busy_w;

endmodule

[dv/tb.sv]
// Self-checking testbench for bounded_stack_with_search_top: push, pop, search and dump
// words against an in-bench stack model, with capacity writes between phases.
// Depends on bsws_pkg and the RTL of the bounded stack with search.
module tb;

  localparam int unsigned DEPTH         = 32;
  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 40;

  typedef struct packed {
    logic signed [bsws_pkg::WORD_W-1:0] data;
    logic                               found;
    logic                               empty_res;
    logic                               last;
  } stack_result_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start;
  logic                               busy;
  logic [1:0]                         op_i;
  logic signed [bsws_pkg::WORD_W-1:0] value_i;
  logic                               res_valid_o;
  logic signed [bsws_pkg::WORD_W-1:0] data_o;
  logic                               found_o;
  logic                               empty_res_o;
  logic                               last_o;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [bsws_pkg::CAP_W-1:0]         cfg_data_i;

  // Stack model state
  logic [bsws_pkg::WORD_W-1:0] model_store [DEPTH];
  int unsigned                 model_fill;
  logic [bsws_pkg::CAP_W-1:0]  model_capacity;
  stack_result_t               expected_words [$];
  stack_result_t               want_word;

  int unsigned err_count;
  int unsigned quiet_cycles;
  bit          sender_idle;

  bounded_stack_with_search_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .op_i       (op_i),
    .value_i    (value_i),
    .res_valid_o(res_valid_o),
    .data_o     (data_o),
    .found_o    (found_o),
    .empty_res_o(empty_res_o),
    .last_o     (last_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Update the stack model for one accepted command and queue the words it yields
  task automatic predict_stack_results(input bsws_pkg::op_e op,
                                       input logic [bsws_pkg::WORD_W-1:0] value);
    int unsigned   limit;
    bit            hit;
    stack_result_t res;
    limit = (model_capacity > DEPTH) ? DEPTH : model_capacity;
    res   = '0;
    case (op)
      bsws_pkg::OP_PUSH: begin
        if (model_fill < limit) begin
          model_store[model_fill] = value;
          model_fill++;
        end
      end
      bsws_pkg::OP_POP: begin
        res.last = 1'b1;
        if (model_fill == 0) begin
          res.data      = bsws_pkg::EMPTY_WORD;
          res.empty_res = 1'b1;
        end else begin
          model_fill--;
          res.data = model_store[model_fill];
        end
        expected_words.push_back(res);
      end
      bsws_pkg::OP_SEARCH: begin
        hit = 1'b0;
        for (int unsigned i = 0; i < model_fill; i++) begin
          if (model_store[i] == value) hit = 1'b1;
        end
        res.found = hit;
        res.last  = 1'b1;
        expected_words.push_back(res);
      end
      default: begin
        if (model_fill == 0) begin
          res.data      = bsws_pkg::EMPTY_WORD;
          res.empty_res = 1'b1;
          res.last      = 1'b1;
          expected_words.push_back(res);
        end else begin
          for (int unsigned i = model_fill; i > 0; i--) begin
            res.data = model_store[i-1];
            res.last = (i == 1);
            expected_words.push_back(res);
          end
        end
      end
    endcase
  endtask

  // Leaves start high after the accept edge so back-to-back commands need no gap
  task automatic send_word(input bsws_pkg::op_e op, input logic [bsws_pkg::WORD_W-1:0] value);
    if (sender_idle && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start   <= 1'b1;
    op_i    <= op;
    value_i <= value;
    do @(posedge clk_i); while (busy);
    predict_stack_results(op, value);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic write_capacity(input logic [bsws_pkg::CAP_W-1:0] cap);
    drain_results();
    // let a trailing push settle before touching the register
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_capacity = cap;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [bsws_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Favor keys that are on the stack so hits are common
  function automatic logic [bsws_pkg::WORD_W-1:0] rand_search_key();
    if (model_fill > 0 && $urandom_range(0, 1) == 1)
      return model_store[$urandom_range(0, model_fill - 1)];
    return rand_word();
  endfunction

  function automatic bsws_pkg::op_e pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return bsws_pkg::OP_PUSH;
    if (r < 75) return bsws_pkg::OP_POP;
    if (r < 88) return bsws_pkg::OP_SEARCH;
    return bsws_pkg::OP_DUMP;
  endfunction

  task automatic test_empty_stack();
    send_word(bsws_pkg::OP_POP, 32'h0);
    send_word(bsws_pkg::OP_DUMP, 32'hFFFF_FFFF);
    send_word(bsws_pkg::OP_SEARCH, 32'h0);
  endtask

  task automatic test_extreme_words();
    send_word(bsws_pkg::OP_PUSH, 32'h8000_0000);
    send_word(bsws_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_word(bsws_pkg::OP_PUSH, 32'h0000_0000);
    send_word(bsws_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_word(bsws_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    send_word(bsws_pkg::OP_SEARCH, 32'h1234_5678);
    send_word(bsws_pkg::OP_SEARCH, 32'hFFFF_FFFF);
    send_word(bsws_pkg::OP_DUMP, 32'h0);
    repeat (4) send_word(bsws_pkg::OP_POP, 32'h0);
    send_word(bsws_pkg::OP_POP, 32'h0);
  endtask

  task automatic test_capacity_edges();
    write_capacity(6'd1);
    send_word(bsws_pkg::OP_PUSH, 32'h0000_00A5);
    send_word(bsws_pkg::OP_PUSH, 32'h0000_005A);
    send_word(bsws_pkg::OP_SEARCH, 32'h0000_005A);
    send_word(bsws_pkg::OP_POP, 32'h0);
    write_capacity(6'd0);
    send_word(bsws_pkg::OP_PUSH, 32'h1111_1111);
    send_word(bsws_pkg::OP_POP, 32'h0);
    write_capacity(6'd32);
    repeat (3) send_word(bsws_pkg::OP_PUSH, rand_word());
    // lower capacity under the fill count: stored words stay put
    write_capacity(6'd2);
    send_word(bsws_pkg::OP_POP, 32'h0);
    send_word(bsws_pkg::OP_PUSH, 32'h2222_2222);
    send_word(bsws_pkg::OP_POP, 32'h0);
    send_word(bsws_pkg::OP_PUSH, 32'h3333_3333);
    send_word(bsws_pkg::OP_DUMP, 32'h0);
  endtask

  task automatic test_full_depth();
    write_capacity(6'd63);
    repeat (DEPTH + 2) send_word(bsws_pkg::OP_PUSH, rand_word());
    send_word(bsws_pkg::OP_DUMP, 32'h0);
    send_word(bsws_pkg::OP_SEARCH, model_store[0]);
    send_word(bsws_pkg::OP_SEARCH, rand_word());
  endtask

  task automatic run_random_phase(input logic [bsws_pkg::CAP_W-1:0] cap,
                                  input int unsigned n_items, input bit idle_on);
    bsws_pkg::op_e op;
    write_capacity(cap);
    sender_idle = idle_on;
    for (int unsigned i = 0; i < n_items; i++) begin
      op = pick_op();
      if (op == bsws_pkg::OP_SEARCH) send_word(op, rand_search_key());
      else send_word(op, rand_word());
      // hold off once until every outstanding word is back
      if (i == n_items / 2 && cap == 6'd5) drain_results();
    end
    sender_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_random_phase(6'd32, 60, 1'b1);
    run_random_phase(6'd63, 50, 1'b0);
    run_random_phase(6'd1, 30, 1'b1);
    run_random_phase(6'd0, 20, 1'b1);
    run_random_phase(6'($urandom_range(0, 63)), 50, 1'b1);
    run_random_phase(6'd5, 40, 1'b1);
  endtask

  // Compare every shown word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: data %0d found %0b empty_res %0b last %0b",
               data_o, found_o, empty_res_o, last_o);
        err_count++;
      end else begin
        want_word = expected_words.pop_front();
        if (data_o !== want_word.data) begin
          $error("data: expected %0d, got %0d", want_word.data, data_o);
          err_count++;
        end
        if (found_o !== want_word.found) begin
          $error("found: expected %0b, got %0b", want_word.found, found_o);
          err_count++;
        end
        if (empty_res_o !== want_word.empty_res) begin
          $error("empty_res: expected %0b, got %0b", want_word.empty_res, empty_res_o);
          err_count++;
        end
        if (last_o !== want_word.last) begin
          $error("last: expected %0b, got %0b", want_word.last, last_o);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bounded_stack_with_search_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    op_i           <= bsws_pkg::OP_PUSH;
    value_i        <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= bsws_pkg::CAP_RESET;
    model_fill     = 0;
    model_capacity = bsws_pkg::CAP_RESET;
    err_count      = 0;
    sender_idle    = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stack();
    test_extreme_words();
    test_capacity_edges();
    test_full_depth();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("bounded_stack_with_search_top verification clean");
    end else begin
      $display("bounded_stack_with_search_top verification failed");
    end
    $finish;
  end

endmodule
